>>> sv/necd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necd_pkg: shared types and constants for the NEC IR frame decoder
// Nominal pulse durations, burst positions, status codes, queue word type
// and the duration window test.
// ----------------------------------------------------------------------------
package necd_pkg;

    localparam int DUR_W      = 15;
    localparam int MARGIN_W   = 9;
    localparam int CODE_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int TOTAL_W    = 4;
    localparam int POS_W      = 6;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 9'd200;

    localparam logic [DUR_W-1:0] NOM_LEAD_MARK  = 15'd9000;
    localparam logic [DUR_W-1:0] NOM_LEAD_SPACE = 15'd4500;
    localparam logic [DUR_W-1:0] NOM_REP_SPACE  = 15'd2250;
    localparam logic [DUR_W-1:0] NOM_BIT_MARK   = 15'd560;
    localparam logic [DUR_W-1:0] NOM_ZERO_SPACE = 15'd560;
    localparam logic [DUR_W-1:0] NOM_ONE_SPACE  = 15'd1690;

    // positions are 0-based symbol indexes within a burst
    localparam logic [POS_W-1:0] POS_LEADER     = 6'd0;
    localparam logic [POS_W-1:0] POS_REPEAT_END = 6'd1;   // 2-symbol burst
    localparam logic [POS_W-1:0] POS_ADDR_LAST  = 6'd16;
    localparam logic [POS_W-1:0] POS_BIT_LAST   = 6'd32;
    localparam logic [POS_W-1:0] POS_FRAME_END  = 6'd33;  // 34-symbol burst
    localparam logic [POS_W-1:0] POS_MAX        = 6'd63;

    // code store
    localparam int STORE_DEPTH = 10;
    localparam int STORE_IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int STORE_CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [STORE_CNT_W-1:0] STORE_FULL = STORE_CNT_W'(STORE_DEPTH);

    // burst queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    typedef enum logic [STATUS_W-1:0] {
        ST_FRAME_OK   = 3'd0,
        ST_REPEAT_OK  = 3'd1,
        ST_FRAME_BAD  = 3'd2,
        ST_REPEAT_BAD = 3'd3,
        ST_UNKNOWN    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        BK_FRAME   = 2'd0,
        BK_REPEAT  = 2'd1,
        BK_UNKNOWN = 2'd2
    } burst_kind_t;

    typedef struct packed {
        burst_kind_t         kind;
        logic                ok;
        logic [CODE_W-1:0]   address;
        logic [CODE_W-1:0]   command;
    } burst_t;

    // strict window test: nom - m < d < nom + m (m < smallest nominal)
    function automatic logic near_nom(input logic [DUR_W-1:0] d,
                                      input logic [DUR_W-1:0] nom,
                                      input logic [MARGIN_W-1:0] m);
        logic [DUR_W:0]   hi;
        logic [DUR_W-1:0] lo;
        hi = {1'b0, nom} + {{(DUR_W+1-MARGIN_W){1'b0}}, m};
        lo = nom - {{(DUR_W-MARGIN_W){1'b0}}, m};
        return ({1'b0, d} < hi) && (d > lo);
    endfunction

endpackage

>>> sv/nec_ir_pulse_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_pulse_frame_decoder: NEC IR pulse-frame decoder, top level
// Path: the accepted final symbol of a burst pushes a summary word into the burst
//   queue; out_valid rises once the result register loads that word from the queue.
// Throughput: one symbol word per cycle; in_stall rises only when the
//   four-entry burst queue is full because the result side is stalled.
// Reset (rst_n, async, low): margin back to 200, burst state, last code and
//   store count cleared; store contents are not cleared.
// ----------------------------------------------------------------------------
// Structure:
//   necd_front - classifies each symbol against the nominal windows
//                (leader 9000/4500, repeat 9000/2250, bit 560/560 or 560/1690)
//                and collects the 16-bit address and command LSB first.
//                On the last symbol it pushes a burst summary word.
//   necd_queue - four-word FIFO; lets the front keep taking symbols while a
//                result waits on out_stall.
//   necd_back  - produces one result word per burst, keeps the last valid
//                code for repeats, appends valid frames to a 10-entry store.
// A burst of 34 symbols is a frame, 2 symbols a repeat, anything else is
// reported as unknown length. The frame stop symbol and the second repeat
// symbol are never checked.
// ----------------------------------------------------------------------------
module nec_ir_pulse_frame_decoder
    import necd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // tolerance margin register
    input  logic                cfg_we,
    input  logic [MARGIN_W-1:0] cfg_wdata,
    // symbol input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [DUR_W-1:0]    mark_time,
    input  logic [DUR_W-1:0]    space_time,
    input  logic                burst_end,
    // result output
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] frame_status,
    output logic [CODE_W-1:0]   code_address,
    output logic [CODE_W-1:0]   code_command,
    output logic                was_stored,
    output logic [TOTAL_W-1:0]  stored_total
);

    logic   q_full;
    logic   q_push;
    burst_t q_push_word;
    logic   q_pop;
    logic   q_valid;
    burst_t q_head_word;

    necd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mark_time  (mark_time),
        .space_time (space_time),
        .burst_end  (burst_end),
        .q_full     (q_full),
        .push       (q_push),
        .push_word  (q_push_word)
    );

    necd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .head_word (q_head_word)
    );

    necd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head_word    (q_head_word),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_status (frame_status),
        .code_address (code_address),
        .code_command (code_command),
        .was_stored   (was_stored),
        .stored_total (stored_total)
    );

endmodule

>>> sv/necd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necd_front: symbol classifier
// Checks each symbol's durations, builds the address and command, and pushes
// one burst summary word into the queue on the final symbol of a burst.
// ----------------------------------------------------------------------------
module necd_front
    import necd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [MARGIN_W-1:0] cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [DUR_W-1:0]    mark_time,
    input  logic [DUR_W-1:0]    space_time,
    input  logic                burst_end,
    input  logic                q_full,
    output logic                push,
    output burst_t              push_word
);

    logic [MARGIN_W-1:0] margin_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                frame_ok_reg, frame_ok_next;
    logic                rep_ok_reg, rep_ok_next;
    logic [CODE_W-1:0]   addr_reg, addr_next;
    logic [CODE_W-1:0]   cmd_reg, cmd_next;
    logic                in_fire;
    logic                lead_mark, bit_mark, one_sp, zero_sp, bit_val;

    assign in_stall = q_full;
    assign in_fire  = in_valid && !in_stall;
    assign push     = in_fire && burst_end;

    always_comb
    begin
        lead_mark = near_nom(mark_time, NOM_LEAD_MARK, margin_reg);
        bit_mark  = near_nom(mark_time, NOM_BIT_MARK, margin_reg);
        one_sp    = near_nom(space_time, NOM_ONE_SPACE, margin_reg);
        zero_sp   = near_nom(space_time, NOM_ZERO_SPACE, margin_reg);
        bit_val   = bit_mark && one_sp;

        frame_ok_next = frame_ok_reg;
        rep_ok_next   = rep_ok_reg;
        addr_next     = addr_reg;
        cmd_next      = cmd_reg;

        if (pos_reg == POS_LEADER)
        begin
            frame_ok_next = lead_mark && near_nom(space_time, NOM_LEAD_SPACE, margin_reg);
            rep_ok_next   = lead_mark && near_nom(space_time, NOM_REP_SPACE, margin_reg);
        end
        else if (pos_reg <= POS_BIT_LAST)
        begin
            if (!bit_val && !(bit_mark && zero_sp))
                frame_ok_next = 1'b0;
            // LSB first: shift in from the top, 16 shifts per field
            if (pos_reg <= POS_ADDR_LAST)
                addr_next = {bit_val, addr_reg[CODE_W-1:1]};
            else
                cmd_next = {bit_val, cmd_reg[CODE_W-1:1]};
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;

        if (pos_reg == POS_FRAME_END)
            push_word.kind = BK_FRAME;
        else if (pos_reg == POS_REPEAT_END)
            push_word.kind = BK_REPEAT;
        else
            push_word.kind = BK_UNKNOWN;
        push_word.ok      = (pos_reg == POS_REPEAT_END) ? rep_ok_next : frame_ok_next;
        push_word.address = addr_next;
        push_word.command = cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg   <= MARGIN_RESET;
            pos_reg      <= '0;
            frame_ok_reg <= 1'b1;
            rep_ok_reg   <= 1'b0;
            addr_reg     <= '0;
            cmd_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                margin_reg <= cfg_wdata;
            if (in_fire)
            begin
                if (burst_end)
                begin
                    pos_reg      <= '0;
                    frame_ok_reg <= 1'b1;
                    rep_ok_reg   <= 1'b0;
                    addr_reg     <= '0;
                    cmd_reg      <= '0;
                end
                else
                begin
                    pos_reg      <= pos_next;
                    frame_ok_reg <= frame_ok_next;
                    rep_ok_reg   <= rep_ok_next;
                    addr_reg     <= addr_next;
                    cmd_reg      <= cmd_next;
                end
            end
        end
    end

endmodule

>>> sv/necd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necd_queue: burst summary queue
// Small register FIFO decoupling the classifier from the result stage.
// ----------------------------------------------------------------------------
module necd_queue
    import necd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  burst_t push_word,
    output logic   full,
    input  logic   pop,
    output logic   q_valid,
    output burst_t head_word
);

    burst_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QUEUE_FULL);
    assign q_valid   = (cnt_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> sv/necd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necd_back: result stage
// Turns burst summaries into result words, keeps the last valid code and
// appends valid frames to the code store until it is full.
// ----------------------------------------------------------------------------
module necd_back
    import necd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  burst_t              head_word,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] frame_status,
    output logic [CODE_W-1:0]   code_address,
    output logic [CODE_W-1:0]   code_command,
    output logic                was_stored,
    output logic [TOTAL_W-1:0]  stored_total
);

    logic [2*CODE_W-1:0]    code_store [STORE_DEPTH];
    logic [STORE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CODE_W-1:0]      last_addr_reg, last_addr_next;
    logic [CODE_W-1:0]      last_cmd_reg, last_cmd_next;
    logic                   out_valid_reg;
    status_t                status_reg, status_next;
    logic [CODE_W-1:0]      addr_reg, addr_next;
    logic [CODE_W-1:0]      cmd_reg, cmd_next;
    logic                   stored_reg, stored_next;
    logic                   frame_good, store_wr;

    assign pop          = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign code_address = addr_reg;
    assign code_command = cmd_reg;
    assign was_stored   = stored_reg;
    assign stored_total = TOTAL_W'(cnt_reg);

    always_comb
    begin
        frame_good     = (head_word.kind == BK_FRAME) && head_word.ok;
        store_wr       = frame_good && (cnt_reg < STORE_FULL);
        cnt_next       = store_wr ? cnt_reg + 1'b1 : cnt_reg;
        last_addr_next = frame_good ? head_word.address : last_addr_reg;
        last_cmd_next  = frame_good ? head_word.command : last_cmd_reg;
        stored_next    = store_wr;
        addr_next      = '0;
        cmd_next       = '0;
        case (head_word.kind)
            BK_FRAME:
            begin
                status_next = head_word.ok ? ST_FRAME_OK : ST_FRAME_BAD;
                if (head_word.ok)
                begin
                    addr_next = head_word.address;
                    cmd_next  = head_word.command;
                end
            end
            BK_REPEAT:
            begin
                status_next = head_word.ok ? ST_REPEAT_OK : ST_REPEAT_BAD;
                addr_next   = last_addr_reg;
                cmd_next    = last_cmd_reg;
            end
            default:
            begin
                status_next = ST_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop && store_wr)
            code_store[cnt_reg[STORE_IDX_W-1:0]] <= {head_word.address, head_word.command};
        if (pop)
        begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
            cmd_reg    <= cmd_next;
            stored_reg <= stored_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            last_addr_reg <= '0;
            last_cmd_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
                last_addr_reg <= last_addr_next;
                last_cmd_reg  <= last_cmd_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> sv/necd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necd_checker: port-level checks for the NEC IR frame decoder
// Watches the result channel: stalled words hold, status matches payload, total never shrinks.
// ----------------------------------------------------------------------------
module necd_checker
    import necd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] frame_status,
    input  logic [CODE_W-1:0]   code_address,
    input  logic [CODE_W-1:0]   code_command,
    input  logic                was_stored,
    input  logic [TOTAL_W-1:0]  stored_total
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_status)
            && $stable(code_address) && $stable(code_command)
            && $stable(was_stored) && $stable(stored_total))
        else $error("result word changed while stalled");

    // only a good frame is ever appended
    a_store_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_stored |-> frame_status == ST_FRAME_OK && stored_total != '0)
        else $error("store append without good frame");

    // rejected frames and unknown bursts carry no code
    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status == ST_FRAME_BAD || frame_status == ST_UNKNOWN)
            |-> code_address == '0 && code_command == '0)
        else $error("nonzero code on rejected burst");

    // a result that follows an accepted one reports a count that never shrinks
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall ##1 out_valid |-> stored_total >= $past(stored_total))
        else $error("stored total decreased");

endmodule

bind nec_ir_pulse_frame_decoder necd_checker u_necd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_status (frame_status),
    .code_address (code_address),
    .code_command (code_command),
    .was_stored   (was_stored),
    .stored_total (stored_total)
);
